/* rtl/core/afrl_pkg.sv */
package afrl_pkg;

    // Shot store
    localparam int unsigned MAX_SHOTS = 8;
    localparam int unsigned SLOT_W    = (MAX_SHOTS > 1) ? $clog2(MAX_SHOTS) : 1;
    localparam int unsigned CNT_W     = $clog2(MAX_SHOTS + 1);

    // Stream widths
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 8;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X         = 3'd0,
        REG_CENTER_Y         = 3'd1,
        REG_BOX_HALF_X       = 3'd2,
        REG_BOX_HALF_Y       = 3'd3,
        REG_STABLE_THRESHOLD = 3'd4,
        REG_WINDOW_MS        = 3'd5
    } cfg_reg_t;

    localparam logic [15:0] CENTER_X_RST   = 16'd320;
    localparam logic [15:0] CENTER_Y_RST   = 16'd240;
    localparam logic [15:0] BOX_HALF_X_RST = 16'd16;
    localparam logic [15:0] BOX_HALF_Y_RST = 16'd14;
    localparam logic [7:0]  THRESHOLD_RST  = 8'd3;
    localparam logic [15:0] WINDOW_MS_RST  = 16'd8000;

    localparam logic [7:0] NO_TARGET_CODE = 8'hFF;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;

    typedef struct packed {
        logic fire;
        logic window_full;
        logic steady;
        logic aimed;
    } result_t;

    function automatic logic [15:0] abs_diff16(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

/* rtl/core/aim_fire_rate_limiter_top.sv */
// Aim-gated fire decision with a sliding-window shot rate limiter.
//
// Input stream (s_*): one update item per control tick. Output stream (m_*):
// exactly one result item per update. Configuration writes go through the
// cfg_* channel (always ready). The user must make them only while the block
// is idle; the block itself does not enforce this.
//
// The accepting edge captures the item, then a single 32-bit subtract/compare
// unit walks the shot store, one slot per cycle, dropping stale timestamps,
// counting live ones and finding the first free slot; a final decision state
// makes the aim, stable-count and fire decision. s_tready is low while an item
// is in work, so a new item is taken only after the last one is decided.
//
// The result sits in an output register: the next item is accepted while it
// waits. If the receiver stalls, the following item finishes its walk and
// holds in its decision cycle until the output register frees.
//
// Reset clears the shot valid bits and the stable count and loads the
// configuration defaults (center 320/240, box 16/14, threshold 3,
// window 8000 ms). No clearing pass is needed.
module aim_fire_rate_limiter_top
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] now_ms, [32] remote_online, [33] vision_online, [34] packet_new,
    // [35] has_target, [43:36] target_code, [59:44] target_x,
    // [75:60] target_y, [76] friction_ready, [77] manual_burst, [79:78] zero
    input  logic [afrl_pkg::IN_DATA_W-1:0]     s_tdata,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] aimed, [1] steady, [2] window_full, [3] fire, [7:4] zero
    output logic [afrl_pkg::OUT_DATA_W-1:0]    m_tdata,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [afrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afrl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam int unsigned NS = afrl_pkg::MAX_SHOTS;
    localparam int unsigned SW = afrl_pkg::SLOT_W;
    localparam int unsigned CW = afrl_pkg::CNT_W;

    state_t state_reg, state_next;

    // Configuration
    logic [15:0] center_x_reg, center_x_next;
    logic [15:0] center_y_reg, center_y_next;
    logic [15:0] box_x_reg, box_x_next;
    logic [15:0] box_y_reg, box_y_next;
    logic [7:0]  thresh_reg, thresh_next;
    logic [15:0] window_reg, window_next;

    // Captured item
    logic [31:0] now_reg, now_next;
    logic        link_ok_reg, link_ok_next;
    logic        fresh_reg, fresh_next;
    logic        gate_bad_reg, gate_bad_next;
    logic [15:0] tx_reg, tx_next;
    logic [15:0] ty_reg, ty_next;

    // Shot store and walk
    logic [31:0]   shot_times_reg [NS];
    logic [NS-1:0] shot_valid_reg, shot_valid_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [CW-1:0] live_reg, live_next;
    logic [SW-1:0] free_idx_reg, free_idx_next;
    logic          free_found_reg, free_found_next;
    logic [7:0]    count_reg, count_next;

    // Output
    logic                  m_valid_reg, m_valid_next;
    afrl_pkg::result_t     res_reg, res_next;

    // Shared age unit
    logic [31:0] age;
    logic        expired;
    logic        slot_live;

    // Decision
    logic        commit;
    logic        aim;
    logic [7:0]  count_inc;
    logic        limited;
    logic        record;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(afrl_pkg::OUT_DATA_W - 4){1'b0}}, res_reg};

    assign age       = now_reg - shot_times_reg[idx_reg];
    assign expired   = (age >= {16'd0, window_reg});
    assign slot_live = shot_valid_reg[idx_reg] && !expired;

    assign commit    = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign aim       = (afrl_pkg::abs_diff16(tx_reg, center_x_reg) <= box_x_reg) &&
                       (afrl_pkg::abs_diff16(ty_reg, center_y_reg) <= box_y_reg);
    assign count_inc = (count_reg == afrl_pkg::COUNT_MAX) ? count_reg : count_reg + 8'd1;
    assign limited   = (live_reg >= CW'(NS));

    always_comb
    begin
        state_next      = state_reg;
        center_x_next   = center_x_reg;
        center_y_next   = center_y_reg;
        box_x_next      = box_x_reg;
        box_y_next      = box_y_reg;
        thresh_next     = thresh_reg;
        window_next     = window_reg;
        now_next        = now_reg;
        link_ok_next    = link_ok_reg;
        fresh_next      = fresh_reg;
        gate_bad_next   = gate_bad_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        shot_valid_next = shot_valid_reg;
        idx_next        = idx_reg;
        live_next       = live_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg;
        res_next        = res_reg;
        record          = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                afrl_pkg::REG_CENTER_X:         center_x_next = cfg_data;
                afrl_pkg::REG_CENTER_Y:         center_y_next = cfg_data;
                afrl_pkg::REG_BOX_HALF_X:       box_x_next    = cfg_data;
                afrl_pkg::REG_BOX_HALF_Y:       box_y_next    = cfg_data;
                afrl_pkg::REG_STABLE_THRESHOLD: thresh_next   = cfg_data[7:0];
                afrl_pkg::REG_WINDOW_MS:        window_next   = cfg_data;
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    now_next        = s_tdata[31:0];
                    link_ok_next    = s_tdata[32] && s_tdata[33];
                    fresh_next      = s_tdata[34];
                    gate_bad_next   = !s_tdata[35] ||
                                      (s_tdata[43:36] == afrl_pkg::NO_TARGET_CODE) ||
                                      !s_tdata[76] || s_tdata[77];
                    tx_next         = s_tdata[59:44];
                    ty_next         = s_tdata[75:60];
                    idx_next        = '0;
                    live_next       = '0;
                    free_idx_next   = '0;
                    free_found_next = 1'b0;
                    state_next      = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // Drop stale stamps, count live ones, note the first free slot
                if (shot_valid_reg[idx_reg] && expired)
                begin
                    shot_valid_next[idx_reg] = 1'b0;
                end
                if (slot_live)
                begin
                    live_next = live_reg + CW'(1);
                end
                else if (!free_found_reg)
                begin
                    free_idx_next   = idx_reg;
                    free_found_next = 1'b1;
                end
                if (idx_reg == SW'(NS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    res_next             = '0;
                    res_next.window_full = limited;
                    if (!link_ok_reg)
                    begin
                        count_next = '0;
                    end
                    else if (!fresh_reg)
                    begin
                        count_next = count_reg;
                    end
                    else if (gate_bad_reg)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        count_next      = aim ? count_inc : 8'd0;
                        res_next.aimed  = aim;
                        res_next.steady = ((aim ? count_inc : 8'd0) >= thresh_reg);
                        res_next.fire   = aim && (count_inc >= thresh_reg) && !limited;
                        if (res_next.fire)
                        begin
                            record                         = 1'b1;
                            shot_valid_next[free_idx_reg]  = 1'b1;
                        end
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            center_x_reg   <= afrl_pkg::CENTER_X_RST;
            center_y_reg   <= afrl_pkg::CENTER_Y_RST;
            box_x_reg      <= afrl_pkg::BOX_HALF_X_RST;
            box_y_reg      <= afrl_pkg::BOX_HALF_Y_RST;
            thresh_reg     <= afrl_pkg::THRESHOLD_RST;
            window_reg     <= afrl_pkg::WINDOW_MS_RST;
            shot_valid_reg <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
            live_reg       <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            center_x_reg   <= center_x_next;
            center_y_reg   <= center_y_next;
            box_x_reg      <= box_x_next;
            box_y_reg      <= box_y_next;
            thresh_reg     <= thresh_next;
            window_reg     <= window_next;
            shot_valid_reg <= shot_valid_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
            idx_reg        <= idx_next;
            live_reg       <= live_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        link_ok_reg  <= link_ok_next;
        fresh_reg    <= fresh_next;
        gate_bad_reg <= gate_bad_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (record)
        begin
            shot_times_reg[free_idx_reg] <= now_reg;
        end
    end

    // Checks

    a_walk_length: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##(NS + 1) (state_reg == ST_DONE))
        else $error("walk did not reach decision after one pass over the store");

    a_fire_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && record) |-> (!limited && free_found_reg))
        else $error("fire issued with a full shot window");

    a_fire_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && record) |=> shot_valid_reg[$past(free_idx_reg)])
        else $error("fired shot not recorded");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (live_reg == CW'($countones(shot_valid_reg))))
        else $error("live count disagrees with valid bits");

endmodule
